/* rtl/core/lrcv_pkg.sv */
// shared types and constants for the log record checksum validator
// no dependencies
package lrcv_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_MULT  = 32'd16777619;

    localparam int CNT_W = 3;

    typedef logic [31:0] t_hash;
    typedef logic [7:0]  t_byte;

endpackage

/* rtl/core/log_record_checksum_validator_core.sv */
// log record checksum validator: sequencer around one shared fnv step unit
// header item: busy after the accept while it hashes magic, sequence and page bytes (S_MAG, S_H1, S_SEQ, S_PAGE)
// payload item: hashed in the accept cycle; last byte adds the S_FIN finish step, result registered
// the finish cycle waits while an earlier result is still held at the output
// synchronous active-low reset clears state, flags, counters and output valid, payload hash to fnv basis
// depends on lrcv_pkg and lrcv_fnv_step
module log_record_checksum_validator_core #(
    parameter int PAGE_ID_BYTES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_is_header,
    input  logic [31:0]           i_magic_word,
    input  logic [63:0]           i_sequence_number,
    input  logic [31:0]           i_page_number,
    input  logic [31:0]           i_stored_checksum,
    input  lrcv_pkg::t_byte       i_payload_byte,
    input  logic                  i_last_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lrcv_pkg::t_hash       o_computed_checksum,
    output logic                  o_record_ok,
    output logic                  o_scan_stopped,
    output logic [63:0]           o_next_sequence,
    output logic [31:0]           o_valid_count
);
    import lrcv_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAG  = 3'd1;
    localparam logic [2:0] S_H1   = 3'd2;
    localparam logic [2:0] S_SEQ  = 3'd3;
    localparam logic [2:0] S_PAGE = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [CNT_W-1:0] PAGE_LAST = CNT_W'(PAGE_ID_BYTES - 1);

    logic [2:0]       r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_exp_magic;
    logic [31:0]      r_magic;
    logic [31:0]      r_page;
    t_hash            r_acc;
    t_hash            r_h1;
    t_hash            r_hhash;
    t_hash            r_phash;
    logic [63:0]      r_held_seq;
    logic [31:0]      r_held_ck;
    logic             r_magic_ok;
    logic             r_stopped;
    logic [63:0]      r_next_seq;
    logic [31:0]      r_count;
    logic             r_out_valid;
    t_hash            r_out_sum;
    logic             r_out_ok;

    t_hash w_unit_h;
    t_byte w_unit_b;
    t_hash w_unit_o;
    t_byte w_page_byte;
    t_hash w_sum;
    logic  w_ok;
    logic  w_out_free;
    logic  w_accept;
    logic [63:0] w_cand;

    lrcv_fnv_step u_step (
        .i_hash (w_unit_h),
        .i_byte (w_unit_b),
        .o_hash (w_unit_o)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_page_byte = r_cnt[CNT_W-1] ? 8'd0 : r_page[8*r_cnt[1:0] +: 8];

    always_comb begin
        w_unit_h = r_acc;
        w_unit_b = 8'd0;
        case (r_state)
            S_IDLE: begin
                w_unit_h = r_phash;
                w_unit_b = i_payload_byte;
            end
            S_MAG:  w_unit_b = r_magic[8*r_cnt[1:0] +: 8];
            S_H1:   w_unit_b = 8'd0;
            S_SEQ:  w_unit_b = r_held_seq[8*r_cnt +: 8];
            S_PAGE: w_unit_b = w_page_byte;
            S_FIN:  w_unit_h = r_hhash;
            default: w_unit_b = 8'd0;
        endcase
    end

    assign w_sum  = w_unit_o ^ r_phash;
    assign w_ok   = !r_stopped && r_magic_ok && (w_sum == r_held_ck);
    assign w_cand = r_held_seq + 64'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_exp_magic <= '0;
            r_hhash     <= '0;
            r_phash     <= FNV_BASIS;
            r_held_seq  <= '0;
            r_held_ck   <= '0;
            r_magic_ok  <= 1'b0;
            r_stopped   <= 1'b0;
            r_next_seq  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_exp_magic <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_is_header) begin
                            r_magic    <= i_magic_word;
                            r_page     <= i_page_number;
                            r_held_seq <= i_sequence_number;
                            r_held_ck  <= i_stored_checksum;
                            r_magic_ok <= (i_magic_word == r_exp_magic);
                            r_phash    <= FNV_BASIS;
                            r_acc      <= FNV_BASIS;
                            r_cnt      <= '0;
                            r_state    <= S_MAG;
                        end else begin
                            r_phash <= w_unit_o;
                            if (i_last_byte) begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_MAG: begin
                    r_acc <= w_unit_o;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(3)) begin
                        r_state <= S_H1;
                    end
                end
                S_H1: begin
                    r_h1    <= w_unit_o;
                    r_acc   <= FNV_BASIS;
                    r_cnt   <= '0;
                    r_state <= S_SEQ;
                end
                S_SEQ: begin
                    r_acc <= w_unit_o;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == '1) begin
                        r_state <= S_PAGE;
                    end
                end
                S_PAGE: begin
                    r_acc <= w_unit_o;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == PAGE_LAST) begin
                        r_hhash <= r_h1 ^ w_unit_o;
                        r_state <= S_IDLE;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_sum   <= w_sum;
                        r_out_ok    <= w_ok;
                        r_phash     <= FNV_BASIS;
                        if (w_ok) begin
                            if (w_cand > r_next_seq) begin
                                r_next_seq <= w_cand;
                            end
                            if (r_count != '1) begin
                                r_count <= r_count + 32'd1;
                            end
                        end else begin
                            r_stopped <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // stats are only updated in the finish cycle, so they match the held item
    assign o_out_valid         = r_out_valid;
    assign o_computed_checksum = r_out_sum;
    assign o_record_ok         = r_out_ok;
    assign o_scan_stopped      = r_stopped;
    assign o_next_sequence     = r_next_seq;
    assign o_valid_count       = r_count;

`ifndef SYNTHESIS
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared");

    a_ok_not_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_record_ok) |-> !o_scan_stopped)
        else $error("valid record reported with scan stopped");

    a_header_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_is_header) |=> (r_state == S_MAG))
        else $error("header item did not start hashing");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !w_out_free) |=> (r_state == S_FIN && o_out_valid))
        else $error("finish cycle overwrote a pending result");
`endif

endmodule

/* rtl/core/lrcv_fnv_step.sv */
// one fnv-1a step: xor a byte into the hash, then multiply by the prime
// depends on lrcv_pkg
module lrcv_fnv_step (
    input  lrcv_pkg::t_hash i_hash,
    input  lrcv_pkg::t_byte i_byte,
    output lrcv_pkg::t_hash o_hash
);
    import lrcv_pkg::*;

    t_hash w_mix;

    assign w_mix  = i_hash ^ {24'd0, i_byte};
    assign o_hash = w_mix * FNV_MULT;

endmodule

/* tb/log_record_checksum_validator_core_tb.sv */
// self-checking testbench for log_record_checksum_validator_core: streams records
// through the item channel and checks every record result against a local fnv model
// depends on lrcv_pkg and the validator core rtl
module log_record_checksum_validator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrcv_pkg::*;

    localparam int PAGE_BYTES     = 4;
    localparam int SETTLE_CYCLES  = 13 + PAGE_BYTES + 12;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic        is_header;
        logic [31:0] magic;
        logic [63:0] seq;
        logic [31:0] page;
        logic [31:0] stored;
        t_byte       data;
        logic        last;
    } t_log_item;

    typedef struct packed {
        t_hash       checksum;
        logic        ok;
        logic        stopped;
        logic [63:0] next_seq;
        logic [31:0] count;
    } t_record_result;

    logic        i_clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        out_ready = 1'b0;
    t_log_item   drv_item  = '0;

    logic        in_ready;
    logic        out_valid;
    t_hash       out_checksum;
    logic        out_ok;
    logic        out_stopped;
    logic [63:0] out_next_seq;
    logic [31:0] out_count;

    t_log_item      pending_items[$];
    t_record_result expected_records[$];
    t_record_result want;

    // model state
    logic [31:0] model_magic;
    t_hash       hdr_digest;
    t_hash       body_hash;
    logic [63:0] held_seq;
    logic [31:0] held_sum;
    logic        magic_hit;
    logic        halted;
    logic [63:0] next_seq;
    logic [31:0] ok_count;

    int idle_pct     = 38;
    int errors       = 0;
    int items_queued = 0;
    int items_sent   = 0;
    int records_seen = 0;
    int records_ok   = 0;
    int cfg_writes   = 0;
    int quiet_cycles = 0;

    log_record_checksum_validator_core #(
        .PAGE_ID_BYTES(PAGE_BYTES)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_is_header        (drv_item.is_header),
        .i_magic_word       (drv_item.magic),
        .i_sequence_number  (drv_item.seq),
        .i_page_number      (drv_item.page),
        .i_stored_checksum  (drv_item.stored),
        .i_payload_byte     (drv_item.data),
        .i_last_byte        (drv_item.last),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_computed_checksum(out_checksum),
        .o_record_ok        (out_ok),
        .o_scan_stopped     (out_stopped),
        .o_next_sequence    (out_next_seq),
        .o_valid_count      (out_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_hash fnv_mix(input t_hash h, input t_byte b);
        t_hash x;
        x = h ^ {24'd0, b};
        return x * FNV_MULT;
    endfunction

    function automatic t_hash header_digest(input logic [31:0] magic, input logic [63:0] seq,
                                            input logic [31:0] page);
        t_hash       h1;
        t_hash       h2;
        logic [63:0] page_ext;
        h1 = FNV_BASIS;
        h2 = FNV_BASIS;
        page_ext = {32'd0, page};
        for (int i = 0; i < 4; i++) h1 = fnv_mix(h1, magic[8*i +: 8]);
        for (int i = 0; i < 8; i++) h2 = fnv_mix(h2, seq[8*i +: 8]);
        for (int i = 0; i < PAGE_BYTES; i++) h2 = fnv_mix(h2, page_ext[8*i +: 8]);
        return (h1 * FNV_MULT) ^ h2;
    endfunction

    function automatic void model_reset();
        model_magic = '0;
        hdr_digest  = '0;
        body_hash   = FNV_BASIS;
        held_seq    = '0;
        held_sum    = '0;
        magic_hit   = 1'b0;
        halted      = 1'b0;
        next_seq    = '0;
        ok_count    = '0;
    endfunction

    function automatic void apply_item(input t_log_item it);
        t_record_result r;
        logic [63:0]    cand;
        if (it.is_header) begin
            hdr_digest = header_digest(it.magic, it.seq, it.page);
            held_seq   = it.seq;
            held_sum   = it.stored;
            magic_hit  = (it.magic == model_magic);
            body_hash  = FNV_BASIS;
        end else begin
            body_hash = fnv_mix(body_hash, it.data);
            if (it.last) begin
                r.checksum = (hdr_digest * FNV_MULT) ^ body_hash;
                r.ok = !halted && magic_hit && (r.checksum == held_sum);
                if (r.ok) begin
                    cand = held_seq + 64'd1;
                    if (cand > next_seq) next_seq = cand;
                    if (ok_count != '1) ok_count = ok_count + 32'd1;
                end else begin
                    halted = 1'b1;
                end
                body_hash  = FNV_BASIS;
                r.stopped  = halted;
                r.next_seq = next_seq;
                r.count    = ok_count;
                expected_records.insert(expected_records.size(), r);
            end
        end
    endfunction

    task automatic note_field(input string what, input logic [63:0] got,
                              input logic [63:0] exp_val);
        if (got !== exp_val) begin
            $display("ERROR %0t %s: got %h, want %h", $realtime, what, got, exp_val);
            errors++;
        end
    endtask

    // item driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                apply_item(drv_item);
                items_sent++;
            end
            if (!in_valid || in_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    drv_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= idle_pct);
            if (out_valid && out_ready) begin
                records_seen++;
                if (out_ok) records_ok++;
                if (expected_records.size() == 0) begin
                    note_field("result with no record pending", 64'd1, 64'd0);
                end else begin
                    want = expected_records.pop_front();
                    note_field("computed_checksum", 64'(out_checksum), 64'(want.checksum));
                    note_field("record_ok", 64'(out_ok), 64'(want.ok));
                    note_field("scan_stopped", 64'(out_stopped), 64'(want.stopped));
                    note_field("next_sequence", out_next_seq, want.next_seq);
                    note_field("valid_count", 64'(out_count), 64'(want.count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("log_record_checksum_validator_core: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic t_log_item random_item();
        t_log_item it;
        it.is_header = 1'($urandom);
        it.magic     = $urandom;
        it.seq       = {$urandom, $urandom};
        it.page      = $urandom;
        it.stored    = $urandom;
        it.data      = 8'($urandom);
        it.last      = 1'($urandom);
        return it;
    endfunction

    function automatic void queue_item(input t_log_item it);
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endfunction

    function automatic void add_stray_bytes(input int n);
        t_log_item it;
        for (int i = 0; i < n; i++) begin
            it = random_item();
            it.is_header = 1'b0;
            it.last = 1'b0;
            queue_item(it);
        end
    endfunction

    function automatic void add_stray_header();
        t_log_item it;
        it = random_item();
        it.is_header = 1'b1;
        queue_item(it);
    endfunction

    // fill < 0 picks random payload bytes
    function automatic void add_record(input logic [31:0] magic, input logic [63:0] seq,
                                       input logic [31:0] page, input int len,
                                       input int fill, input bit spoil);
        t_byte     body[$];
        t_hash     h;
        t_byte     b;
        t_log_item it;
        h = FNV_BASIS;
        for (int i = 0; i < len; i++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            body.insert(body.size(), b);
            h = fnv_mix(h, b);
        end
        it = random_item();
        it.is_header = 1'b1;
        it.magic     = magic;
        it.seq       = seq;
        it.page      = page;
        it.stored    = (header_digest(magic, seq, page) * FNV_MULT) ^ h;
        if (spoil) it.stored = it.stored ^ (32'd1 << $urandom_range(31));
        queue_item(it);
        for (int i = 0; i < len; i++) begin
            it = random_item();
            it.is_header = 1'b0;
            it.data      = body[i];
            it.last      = (i == len - 1);
            queue_item(it);
        end
    endfunction

    function automatic int pick_len();
        return ($urandom_range(9) == 0) ? $urandom_range(48, 9) : $urandom_range(8, 1);
    endfunction

    // wild traffic mixes fully random items, foreign magic and corrupted checksums
    function automatic void queue_traffic(input int n, input int seq_bits, input bit wild);
        int          target;
        int          pick;
        logic [63:0] mask;
        logic [63:0] seq;
        logic [31:0] magic;
        target = items_queued + n;
        mask = (seq_bits >= 64) ? '1 : ((64'd1 << seq_bits) - 64'd1);
        while (items_queued < target) begin
            pick  = $urandom_range(99);
            seq   = {$urandom, $urandom} & mask;
            magic = model_magic;
            if (wild && $urandom_range(1)) magic = $urandom;
            if (pick < 8) begin
                add_stray_bytes($urandom_range(3, 1));
            end else if (pick < 13) begin
                add_stray_header();
                add_stray_bytes($urandom_range(3, 0));
            end else if (wild && pick < 35) begin
                queue_item(random_item());
            end else begin
                add_record(magic, seq, $urandom, pick_len(), -1, wild && pick < 55);
            end
        end
    endfunction

    task automatic write_magic(input logic [31:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        model_magic = value;
        cfg_writes++;
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || in_valid || expected_records.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        model_reset();
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        write_magic(32'h0000_0000);

        // payload ahead of the first header, record extremes, header mid-record
        add_stray_bytes(2);
        add_record(32'h0, 64'h0, 32'h0, 1, 8'h00, 1'b0);
        add_record(32'h0, '1, '1, 1, 8'hFF, 1'b0);
        add_stray_header();
        add_stray_bytes(2);
        add_record(32'h0, 64'd7, 32'h8000_0001, 2, -1, 1'b0);
        add_record(32'h0, 64'h8000_0000_0000_0000, 32'h0000_FFFF, 3, -1, 1'b0);
        settle();

        write_magic(32'hFFFF_FFFF);
        queue_traffic(250, 16, 1'b0);
        settle();

        idle_pct = 0;
        write_magic($urandom);
        queue_traffic(200, 40, 1'b0);
        settle();

        idle_pct = 38;
        write_magic($urandom);
        queue_traffic(200, 64, 1'b0);
        add_record(model_magic, 64'hFFFF_FFFF_FFFF_FFFE, $urandom, 2, -1, 1'b0);
        settle();

        // first failure latches the stop, everything after must come back not ok
        add_record(~model_magic, {$urandom, $urandom}, $urandom, 2, -1, 1'b0);
        add_record(model_magic, {$urandom, $urandom}, $urandom, 3, -1, 1'b0);
        add_record(model_magic, {$urandom, $urandom}, $urandom, 2, -1, 1'b1);
        queue_traffic(150, 64, 1'b1);
        settle();

        $display("sent %0d items over %0d magic settings; %0d records checked, %0d valid",
                 items_sent, cfg_writes, records_seen, records_ok);
        if (errors == 0) begin
            $display("log_record_checksum_validator_core: match");
        end else begin
            $display("%0d field errors", errors);
            $display("log_record_checksum_validator_core: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lrcv_pkg.sv
rtl/core/lrcv_fnv_step.sv
rtl/core/log_record_checksum_validator_core.sv
tb/log_record_checksum_validator_core_tb.sv
